@@ src/deque_with_search_macros.svh @@
// assertion macros shared by the deque checker
`ifndef DEQUE_WITH_SEARCH_MACROS_SVH
`define DEQUE_WITH_SEARCH_MACROS_SVH

// same-cycle implication, disabled while in reset
`define DQS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// next-cycle implication, disabled while in reset
`define DQS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

@@ src/dqs_pkg.sv @@
// types and constants for the deque with search
`timescale 1ns / 1ps

package dqs_pkg;

    localparam int DQS_CAPACITY = 16;
    localparam int DATA_W       = 32;
    localparam int REQ_W        = 3;
    localparam int STATUS_W     = 3;
    localparam int OCC_W        = 7;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 48;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DUMP       = 3'd5;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_FOUND    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_APPEND,
        CELL_SHIFT_LEFT,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_WORK
    } state_t;

endpackage

@@ src/deque_with_search.sv @@
// top level of the bounded deque with search and dump
`timescale 1ns / 1ps

// Bounded deque of CAPACITY signed 32-bit values held in a row of cells, cell 0
// holding the front. One request is taken at a time; s_axis_tready is high only
// while the block waits for a request, and a result may still sit unread in the
// output register then. With n the occupancy before a request, pop back turns
// the ring until the back element reaches cell 0, search turns it once round and
// dump turns it once round, giving each element in turn. The row of cells turns
// by one place a cycle, but a dump holds while its output stalls, so search,
// dump and pop back grow with n up to CAPACITY. A push into a full deque is
// refused with status full; pops and dumps of an empty deque report empty.
// Unused request codes give one done result and change nothing.
module deque_with_search #(
    parameter int CAPACITY = dqs_pkg::DQS_CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [2:0] req_type, [34:3] value, [39:35] zero
    input  logic [dqs_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [2:0] status, [34:3] data, [41:35] occupancy, [47:42] zero
    output logic [dqs_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic                              m_axis_tlast
);
    import dqs_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PAD_W = M_TDATA_W - STATUS_W - DATA_W - OCC_W;

    cell_op_t                 op;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] cell_value;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    status_t                  status;
    logic signed [DATA_W-1:0] data;
    logic [OCC_W-1:0]         occupancy;

    dqs_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .req_type    (s_axis_tdata[REQ_W-1:0]),
        .value       (s_axis_tdata[REQ_W+DATA_W-1:REQ_W]),
        .head_data   (cell_data[0]),
        .op          (op),
        .count       (count),
        .cell_value  (cell_value),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .status      (status),
        .data        (data),
        .occupancy   (occupancy),
        .last_of_run (m_axis_tlast)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        dqs_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .op         (op),
            .count      (count),
            .value      (cell_value),
            .left_data  ((i == 0) ? cell_value : cell_data[(i + CAPACITY - 1) % CAPACITY]),
            .right_data (cell_data[(i + 1) % CAPACITY]),
            .head_data  (cell_data[0]),
            .data       (cell_data[i])
        );
    end

    assign m_axis_tdata = {{PAD_W{1'b0}}, occupancy, data, status};

endmodule

@@ src/dqs_cell.sv @@
// one storage cell of the deque chain
`timescale 1ns / 1ps

module dqs_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                                 clk,
    input  dqs_pkg::cell_op_t                    op,
    input  logic [CNT_W-1:0]                     count,
    input  logic signed [dqs_pkg::DATA_W-1:0]    value,
    input  logic signed [dqs_pkg::DATA_W-1:0]    left_data,
    input  logic signed [dqs_pkg::DATA_W-1:0]    right_data,
    input  logic signed [dqs_pkg::DATA_W-1:0]    head_data,
    output logic signed [dqs_pkg::DATA_W-1:0]    data
);
    import dqs_pkg::*;

    localparam logic [CNT_W-1:0] APPEND_POS = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] TAIL_POS   = CNT_W'(IDX + 1);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (op)
            CELL_HOLD:       data_next = data_reg;
            CELL_PUSH_FRONT: data_next = left_data;
            CELL_APPEND:
            begin
                if (count == APPEND_POS)
                begin
                    data_next = value;
                end
            end
            CELL_SHIFT_LEFT: data_next = right_data;
            CELL_ROTATE:
            begin
                // the back cell takes the old front, closing the ring
                if (count == TAIL_POS)
                begin
                    data_next = head_data;
                end
                else
                begin
                    data_next = right_data;
                end
            end
            default:         data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ src/dqs_ctrl.sv @@
// request sequencer, element count and result register of the deque
`timescale 1ns / 1ps

module dqs_ctrl #(
    parameter int CAPACITY = dqs_pkg::DQS_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [dqs_pkg::REQ_W-1:0]             req_type,
    input  logic signed [dqs_pkg::DATA_W-1:0]     value,
    input  logic signed [dqs_pkg::DATA_W-1:0]     head_data,
    output dqs_pkg::cell_op_t                     op,
    output logic [CNT_W-1:0]                      count,
    output logic signed [dqs_pkg::DATA_W-1:0]     cell_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output dqs_pkg::status_t                      status,
    output logic signed [dqs_pkg::DATA_W-1:0]     data,
    output logic [dqs_pkg::OCC_W-1:0]             occupancy,
    output logic                                  last_of_run
);
    import dqs_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

    state_t                   state_reg, state_next;
    logic [REQ_W-1:0]         req_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         step_reg, step_next;
    logic                     found_reg, found_next;

    logic                     out_valid_reg;
    status_t                  out_status_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic [CNT_W-1:0]         out_occ_reg;
    logic                     out_last_reg;

    logic                     accept;
    logic                     out_free;
    logic                     is_full;
    logic                     is_empty;
    logic                     at_tail;
    logic                     emit;
    logic                     done;
    status_t                  emit_status;
    logic signed [DATA_W-1:0] emit_data;
    logic                     emit_last;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);
    assign at_tail  = (step_reg == count_reg - ONE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_WORK;
                end
            end
            S_WORK:
            begin
                if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready    = 1'b0;
        op          = CELL_HOLD;
        emit        = 1'b0;
        done        = 1'b0;
        emit_status = ST_DONE;
        emit_data   = '0;
        emit_last   = 1'b1;
        count_next  = count_reg;
        step_next   = step_reg;
        found_next  = found_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                step_next  = '0;
                found_next = 1'b0;
            end
            S_WORK:
            begin
                case (req_reg)
                    REQ_PUSH_FRONT, REQ_PUSH_BACK:
                    begin
                        if (out_free)
                        begin
                            emit = 1'b1;
                            done = 1'b1;
                            if (is_full)
                            begin
                                emit_status = ST_FULL;
                            end
                            else
                            begin
                                op = (req_reg == REQ_PUSH_FRONT) ? CELL_PUSH_FRONT
                                                                 : CELL_APPEND;
                                count_next = count_reg + ONE;
                            end
                        end
                    end
                    REQ_POP_FRONT:
                    begin
                        if (out_free)
                        begin
                            emit = 1'b1;
                            done = 1'b1;
                            if (is_empty)
                            begin
                                emit_status = ST_EMPTY;
                            end
                            else
                            begin
                                emit_data  = head_data;
                                op         = CELL_SHIFT_LEFT;
                                count_next = count_reg - ONE;
                            end
                        end
                    end
                    REQ_POP_BACK:
                    begin
                        if (is_empty)
                        begin
                            if (out_free)
                            begin
                                emit        = 1'b1;
                                done        = 1'b1;
                                emit_status = ST_EMPTY;
                            end
                        end
                        else if (!at_tail)
                        begin
                            // bring the back element round to cell 0
                            op        = CELL_ROTATE;
                            step_next = step_reg + ONE;
                        end
                        else if (out_free)
                        begin
                            emit       = 1'b1;
                            done       = 1'b1;
                            emit_data  = head_data;
                            op         = CELL_SHIFT_LEFT;
                            count_next = count_reg - ONE;
                        end
                    end
                    REQ_SEARCH:
                    begin
                        if (step_reg != count_reg)
                        begin
                            // full turn of the ring leaves the order as it was
                            op         = CELL_ROTATE;
                            step_next  = step_reg + ONE;
                            found_next = found_reg || (head_data == val_reg);
                        end
                        else if (out_free)
                        begin
                            emit        = 1'b1;
                            done        = 1'b1;
                            emit_status = found_reg ? ST_FOUND : ST_NOTFOUND;
                        end
                    end
                    REQ_DUMP:
                    begin
                        if (out_free)
                        begin
                            emit = 1'b1;
                            if (is_empty)
                            begin
                                done        = 1'b1;
                                emit_status = ST_EMPTY;
                            end
                            else
                            begin
                                emit_data = head_data;
                                emit_last = at_tail;
                                done      = at_tail;
                                op        = CELL_ROTATE;
                                step_next = step_reg + ONE;
                            end
                        end
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            emit = 1'b1;
                            done = 1'b1;
                        end
                    end
                endcase
            end
            default: in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            found_reg <= found_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            val_reg <= value;
        end
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_data_reg   <= emit_data;
            out_occ_reg    <= count_next;
            out_last_reg   <= emit_last;
        end
    end

    assign count       = count_reg;
    assign cell_value  = val_reg;
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign data        = out_data_reg;
    assign occupancy   = OCC_W'(out_occ_reg);
    assign last_of_run = out_last_reg;

endmodule

@@ src/dqs_checker.sv @@
// port-level checks of the deque, bound to the top level
`timescale 1ns / 1ps

`include "deque_with_search_macros.svh"

module dqs_checker #(
    parameter int CAPACITY = dqs_pkg::DQS_CAPACITY
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [dqs_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tlast
);
    import dqs_pkg::*;

    logic [STATUS_W-1:0] st;
    logic [OCC_W-1:0]    occ;

    assign st  = m_axis_tdata[STATUS_W-1:0];
    assign occ = m_axis_tdata[STATUS_W+DATA_W+OCC_W-1:STATUS_W+DATA_W];

    `DQS_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `DQS_ASSERT_IMP(a_occ_bound, clk, rst_n, m_axis_tvalid, occ <= OCC_W'(CAPACITY))
    `DQS_ASSERT_IMP(a_full_occ, clk, rst_n, m_axis_tvalid && st == ST_FULL,
        occ == OCC_W'(CAPACITY) && m_axis_tlast)
    `DQS_ASSERT_IMP(a_empty_occ, clk, rst_n, m_axis_tvalid && st == ST_EMPTY,
        occ == '0 && m_axis_tlast)
    `DQS_ASSERT_IMP(a_search_single, clk, rst_n,
        m_axis_tvalid && (st == ST_FOUND || st == ST_NOTFOUND),
        m_axis_tlast && m_axis_tdata[STATUS_W+DATA_W-1:STATUS_W] == '0)

endmodule

bind deque_with_search dqs_checker #(
    .CAPACITY (CAPACITY)
) u_dqs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ verif/testbench.sv @@
// self-checking testbench for the deque with search and dump
`timescale 1ns / 1ps

module testbench;
    import dqs_pkg::*;

    localparam int          CAP          = DQS_CAPACITY;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          SETTLE       = 2 * CAP + 20;
    localparam int          PRINT_CAP    = 40;
    localparam logic [2:0]  REQ_UNUSED_6 = 3'd6;
    localparam logic [2:0]  REQ_UNUSED_7 = 3'd7;

    typedef struct packed {
        status_t     status;
        logic [31:0] data;
        logic [6:0]  occ;
        logic        last;
    } outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;

    // shadow copy of the ring and the results still owed by the block
    logic [31:0]  ring_slots [CAP];
    int unsigned  ring_head;
    int unsigned  ring_fill;
    outcome_t     outcome_q[$];

    int  errors;
    int  results_seen;
    int  cycle_count;
    bit  src_gaps;
    bit  sink_stalls;
    int  sink_hold;

    deque_with_search dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results owed", cycle_count,
                     outcome_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side back-pressure: mostly short stalls, now and then a long one
    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!sink_stalls)
            m_axis_tready <= 1'b1;
        else
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3:
                begin
                    m_axis_tready <= 1'b0;
                    sink_hold     <= $urandom_range(0, 3);
                end
                4:
                begin
                    m_axis_tready <= 1'b0;
                    sink_hold     <= $urandom_range(6, 20);
                end
                default:
                    m_axis_tready <= 1'b1;
            endcase
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < PRINT_CAP)
            $display("mismatch in %s of result %0d: got %h, want %h (t=%0t)",
                     what, results_seen, got, want, $time);
        errors++;
    endtask

    function automatic void owe(input status_t st, input logic [31:0] d, input logic last);
        outcome_t o;
        o.status = st;
        o.data   = d;
        o.occ    = 7'(ring_fill);
        o.last   = last;
        outcome_q.push_back(o);
    endfunction

    function automatic int unsigned slot_of(input int unsigned offset);
        return (ring_head + offset) % CAP;
    endfunction

    // advance the shadow deque by one accepted request
    function automatic void apply_request(input logic [2:0] req, input logic [31:0] val);
        logic [31:0] d;
        bit          hit;
        case (req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK:
            begin
                if (ring_fill >= CAP)
                    owe(ST_FULL, '0, 1'b1);
                else
                begin
                    if (req == REQ_PUSH_FRONT)
                    begin
                        ring_head = (ring_head == 0) ? CAP - 1 : ring_head - 1;
                        ring_slots[ring_head] = val;
                    end
                    else
                        ring_slots[slot_of(ring_fill)] = val;
                    ring_fill++;
                    owe(ST_DONE, '0, 1'b1);
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK:
            begin
                if (ring_fill == 0)
                    owe(ST_EMPTY, '0, 1'b1);
                else
                begin
                    if (req == REQ_POP_FRONT)
                    begin
                        d = ring_slots[ring_head];
                        ring_head = (ring_head + 1) % CAP;
                    end
                    else
                        d = ring_slots[slot_of(ring_fill - 1)];
                    ring_fill--;
                    owe(ST_DONE, d, 1'b1);
                end
            end
            REQ_SEARCH:
            begin
                hit = 1'b0;
                for (int unsigned i = 0; i < ring_fill; i++)
                    if (ring_slots[slot_of(i)] == val)
                        hit = 1'b1;
                owe(hit ? ST_FOUND : ST_NOTFOUND, '0, 1'b1);
            end
            REQ_DUMP:
            begin
                if (ring_fill == 0)
                    owe(ST_EMPTY, '0, 1'b1);
                else
                    for (int unsigned i = 0; i < ring_fill; i++)
                        owe(ST_DONE, ring_slots[slot_of(i)], i + 1 == ring_fill);
            end
            default:
                owe(ST_DONE, '0, 1'b1);
        endcase
    endfunction

    task automatic check_result(input logic [M_TDATA_W-1:0] word, input logic last);
        outcome_t want;
        if (outcome_q.size() == 0)
        begin
            report_mismatch("unexpected result", word[34:3], '0);
            return;
        end
        want = outcome_q.pop_front();
        if (word[2:0] !== want.status)
            report_mismatch("status", 32'(word[2:0]), 32'(want.status));
        if (word[34:3] !== want.data)
            report_mismatch("data", word[34:3], want.data);
        if (word[41:35] !== want.occ)
            report_mismatch("occupancy", 32'(word[41:35]), 32'(want.occ));
        if (last !== want.last)
            report_mismatch("tlast", 32'(last), 32'(want.last));
        results_seen++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_result(m_axis_tdata, m_axis_tlast);
    end

    function automatic int pick_gap();
        if (!src_gaps)
            return 0;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6:
                return $urandom_range(1, 3);
            7:
                return $urandom_range(8, 25);
            default:
                return 0;
        endcase
    endfunction

    // valid stays high across back-to-back requests; it is lowered only for a gap or while draining
    task automatic send_request(input logic [2:0] req, input logic [31:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, val, req};
        do
            @(posedge clk);
        while (!s_axis_tready);
        apply_request(req, val);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outcome_q.size() != 0);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            1, 2, 3:
                return 32'($signed($urandom_range(0, 7)) - 3);
            default:
                return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_search_value();
        if (ring_fill > 0 && $urandom_range(0, 1))
            return ring_slots[slot_of($urandom_range(0, ring_fill - 1))];
        return pick_value();
    endfunction

    task automatic test_empty_deque();
        send_request(REQ_POP_FRONT, 32'h1234_5678);
        send_request(REQ_POP_BACK, '0);
        send_request(REQ_DUMP, '0);
        send_request(REQ_SEARCH, '0);
        send_request(REQ_UNUSED_6, 32'hffff_ffff);
        send_request(REQ_UNUSED_7, 32'h8000_0000);
        wait_drained();
    endtask

    // fill from both ends across the wrap point, then refuse, search, dump, pop
    task automatic test_full_deque();
        logic [31:0] edge_vals [4];
        edge_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff};
        for (int i = 0; i < CAP; i++)
            send_request(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT,
                         (i < 4) ? edge_vals[i] : $urandom);
        send_request(REQ_PUSH_FRONT, 32'h0bad_0001);
        send_request(REQ_PUSH_BACK, 32'h0bad_0002);
        send_request(REQ_SEARCH, 32'h8000_0000);
        send_request(REQ_SEARCH, 32'h0000_0001);
        send_request(REQ_DUMP, '0);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_POP_BACK, '0);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count);
        bit          grow;
        int          pick;
        int          push_pct;
        int          pop_pct;
        logic [2:0]  req;
        logic [31:0] val;
        grow = 1'b0;
        for (int n = 0; n < count; n++)
        begin
            // each segment of 40 requests draws a new idling mix; the first runs flat out
            if (n % 40 == 0)
            begin
                src_gaps    = (n == 0) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
                sink_stalls = (n == 0) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
                if (n % 120 == 0 && n != 0)
                    wait_drained();
            end
            if (ring_fill == CAP && $urandom_range(0, 2) == 0)
                grow = 1'b0;
            else if (ring_fill == 0)
                grow = 1'b1;
            else if ($urandom_range(0, 24) == 0)
                grow = ~grow;
            push_pct = grow ? 55 : 18;
            pop_pct  = grow ? 15 : 52;
            pick = $urandom_range(0, 99);
            val  = pick_value();
            if (pick < push_pct)
                req = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
            else if (pick < push_pct + pop_pct)
                req = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
            else if (pick < 88)
            begin
                req = REQ_SEARCH;
                val = pick_search_value();
            end
            else if (pick < 96)
                req = REQ_DUMP;
            else
                req = $urandom_range(0, 1) ? REQ_UNUSED_7 : REQ_UNUSED_6;
            send_request(req, val);
        end
        wait_drained();
    endtask

    initial
    begin
        errors       = 0;
        results_seen = 0;
        cycle_count  = 0;
        sink_hold    = 0;
        src_gaps     = 1'b1;
        sink_stalls  = 1'b1;
        ring_head    = 0;
        ring_fill    = 0;
        foreach (ring_slots[i])
            ring_slots[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_deque();
        test_full_deque();
        test_random_traffic(320);

        repeat (SETTLE) @(posedge clk);
        if (outcome_q.size() != 0)
            report_mismatch("missing results", 32'(outcome_q.size()), '0);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
